// ----- rtl/dsep_pkg.sv -----
// Shared types and constants for the active-trail search block.
`default_nettype none
package dsep_pkg;
  localparam int NODES_DEF = 32;
  localparam int NODE_W = 6;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ACT_EDGE  = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // Command handed from the front part to the search engine.
  typedef struct packed {
    logic              bad;
    logic [NODE_W-1:0] xi;
    logic [NODE_W-1:0] xj;
  } query_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_SEARCH,
    ST_EXPAND,
    ST_WALK,
    ST_TRAIL,
    ST_TAIL,
    ST_SEP
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/dsep_front.sv -----
// Front part: decodes items, keeps node count, edge rows, observed set; queues queries.
`default_nettype none
module dsep_front #(
  parameter int NODES = dsep_pkg::NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [1:0]                  action,
  input  wire logic [dsep_pkg::NODE_W-1:0] node_a,
  input  wire logic [dsep_pkg::NODE_W-1:0] node_b,
  input  wire logic                        cfg_we,
  input  wire logic [dsep_pkg::NODE_W-1:0] cfg_wdata,
  input  wire logic                        q_pop,
  output logic                             q_empty,
  output logic                             q_full,
  output dsep_pkg::query_t                 q_head,
  output logic [NODES:0]                   z_head,
  output logic [NODES:0]                   act,
  output logic [NODES:0]                   edges [NODES+1]
);
  logic [dsep_pkg::NODE_W-1:0] node_count;
  logic [NODES:0]              observed;
  logic [dsep_pkg::NODE_W-1:0] n_eff;
  logic va, vb;
  dsep_pkg::query_t            qq   [dsep_pkg::QDEPTH];
  logic [NODES:0]              qz   [dsep_pkg::QDEPTH];
  logic                        wp, rp;
  logic [1:0]                  cnt;

  always_comb begin
    n_eff = (node_count > dsep_pkg::NODE_W'(NODES)) ? dsep_pkg::NODE_W'(NODES) : node_count;
    for (int i = 0; i <= NODES; i++) act[i] = (i >= 1) && (i <= int'(n_eff));
    va = (node_a != '0) && (node_a <= n_eff);
    vb = (node_b != '0) && (node_b <= n_eff);
  end

  assign q_empty = (cnt == 2'd0);
  assign q_full  = (cnt == 2'd2);
  assign q_head  = qq[rp];
  assign z_head  = qz[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dsep_pkg::NODE_W'(32);
      observed   <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
      for (int i = 0; i <= NODES; i++) edges[i] <= '0;
    end else begin
      if (cfg_we) node_count <= cfg_wdata;
      if (take) begin
        case (dsep_pkg::action_t'(action))
          dsep_pkg::ACT_EDGE:  if (va && vb) edges[node_a][node_b] <= 1'b1;
          dsep_pkg::ACT_MARK:  if (va) observed[node_a] <= 1'b1;
          dsep_pkg::ACT_QUERY: begin
            qq[wp] <= '{bad: !(va && vb), xi: node_a, xj: node_b};
            qz[wp] <= observed & act;
            observed <= '0;
            wp <= ~wp;
          end
          dsep_pkg::ACT_CLEAR: for (int i = 0; i <= NODES; i++) edges[i] <= '0;
          default: ;
        endcase
      end
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, take && (action == dsep_pkg::ACT_QUERY)} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/dsep_engine.sv -----
// Back part: ancestor closure, Bayes-ball search and trail walk.
`default_nettype none
module dsep_engine #(
  parameter int NODES = dsep_pkg::NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  wire dsep_pkg::query_t            q_head,
  input  wire logic [NODES:0]              z_head,
  input  wire logic [NODES:0]              act,
  input  wire logic [NODES:0]              edges [NODES+1],
  output logic                             q_pop,
  output logic                             eng_busy,
  output logic                             result_valid,
  output logic [dsep_pkg::NODE_W-1:0]      trail_node,
  output logic                             separated,
  output logic                             truncated,
  output logic                             last
);
  localparam int PW = $clog2(2*(NODES+1));
  localparam int IW = $clog2(NODES+1);
  localparam int CW = $clog2(NODES+1);
  dsep_pkg::state_t state, state_next;
  logic [NODES:0]   z, anc, pend0, pend1, vis0, vis1;
  logic             chg, grow, close_done;
  logic [dsep_pkg::NODE_W-1:0] xi, xj, cur, predv, predp;
  logic [dsep_pkg::NODE_W-1:0] pred [NODES+1];
  logic [IW-1:0]    y, sweep, py;
  logic             d, cut, pd, pvis, ptgt, chain_end;
  logic [CW-1:0]    steps;
  logic [NODES:0]   parcol, anyp, xi_hot;
  logic [2*(NODES+1)-1:0] pend;
  logic             found;
  logic [PW-1:0]    idx;
  logic [NODES:0]   s_par, s_ch;
  logic             do_par, do_ch;

  always_comb begin
    for (int i = 0; i <= NODES; i++) parcol[i] = edges[i][y] & act[i];
    for (int i = 0; i <= NODES; i++) begin
      pend[2*i]   = pend0[i];
      pend[2*i+1] = pend1[i];
    end
    found = 1'b0;
    idx = '0;
    for (int i = 2*(NODES+1)-1; i >= 0; i--)
      if (pend[i]) begin
        found = 1'b1;
        idx = PW'(i);
      end
    // Lowest pending pair: node, direction, already seen, reaches the target.
    py = idx[PW-1:1];
    pd = idx[0];
    pvis = pd ? vis1[py] : vis0[py];
    ptgt = !z[py] && (py == xj[IW-1:0]);
    // Predecessor chain ends where it loops on itself or after NODES nodes.
    predv = pred[cur[IW-1:0]];
    predp = pred[predv[IW-1:0]];
    chain_end = (predv == predp) || (steps + CW'(1) == CW'(NODES));
    // Ancestor closure: one parent column per sweep slot.
    anyp = '0;
    for (int i = 0; i <= NODES; i++) anyp[i] = edges[i][sweep] & act[i];
    grow = anc[sweep] && ((anyp & ~anc) != '0);
    close_done = (sweep == IW'(NODES)) && !chg && !grow;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      dsep_pkg::ST_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        state_next = q_head.bad ? dsep_pkg::ST_SEP : dsep_pkg::ST_CLOSE;
      end
      dsep_pkg::ST_CLOSE: if (close_done) state_next = dsep_pkg::ST_SEARCH;
      dsep_pkg::ST_SEARCH: begin
        if (!found) state_next = dsep_pkg::ST_SEP;
        else if (!pvis) state_next = ptgt ? dsep_pkg::ST_WALK : dsep_pkg::ST_EXPAND;
      end
      dsep_pkg::ST_EXPAND: state_next = dsep_pkg::ST_SEARCH;
      dsep_pkg::ST_WALK:  if (chain_end) state_next = dsep_pkg::ST_TRAIL;
      dsep_pkg::ST_TRAIL: if (chain_end) state_next = dsep_pkg::ST_TAIL;
      dsep_pkg::ST_TAIL:  state_next = dsep_pkg::ST_IDLE;
      dsep_pkg::ST_SEP:   state_next = dsep_pkg::ST_IDLE;
      default: state_next = dsep_pkg::ST_IDLE;
    endcase
  end

  assign eng_busy = (state != dsep_pkg::ST_IDLE);
  assign s_par = parcol;
  assign s_ch  = edges[y] & act;
  assign do_ch  = (d && !z[y]) || (!d && !z[y]);
  assign do_par = (d && !z[y]) || (!d && anc[y]);
  assign xi_hot = {{NODES{1'b0}}, 1'b1} << xi[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsep_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      case (state)
        dsep_pkg::ST_IDLE: if (!q_empty) begin
          xi <= q_head.xi;
          xj <= q_head.xj;
          z <= z_head;
          anc <= z_head;
          chg <= 1'b0;
          sweep <= IW'(1);
        end
        dsep_pkg::ST_CLOSE: begin
          if (grow) anc <= anc | anyp;
          if (sweep == IW'(NODES)) begin
            sweep <= IW'(1);
            chg <= 1'b0;
            if (close_done) begin
              pend0 <= '0;
              pend1 <= xi_hot;
              vis0 <= '0;
              vis1 <= '0;
              for (int i = 0; i <= NODES; i++) pred[i] <= (i == int'(xi)) ? xi : '0;
            end
          end else begin
            sweep <= sweep + IW'(1);
            if (grow) chg <= 1'b1;
          end
        end
        dsep_pkg::ST_SEARCH: if (found) begin
          if (pd) pend1[py] <= 1'b0;
          else pend0[py] <= 1'b0;
          if (!pvis) begin
            y <= py;
            d <= pd;
            if (ptgt) begin
              cur <= xj;
              steps <= '0;
            end else if (pd) vis1[py] <= 1'b1;
            else vis0[py] <= 1'b1;
          end
        end
        dsep_pkg::ST_EXPAND: begin
          pend1 <= pend1 | ({(NODES+1){do_par}} & s_par);
          pend0 <= pend0 | ({(NODES+1){do_ch}} & s_ch);
          for (int v = 1; v <= NODES; v++)
            if ((do_par && s_par[v] && !vis1[v]) || (do_ch && s_ch[v] && !vis0[v]))
              pred[v] <= dsep_pkg::NODE_W'(y);
        end
        dsep_pkg::ST_WALK: begin
          // Dry walk of the chain to learn the truncation flag up front.
          if (chain_end) begin
            cut <= predv != predp;
            cur <= xj;
            steps <= '0;
          end else begin
            cur <= predv;
            steps <= steps + CW'(1);
          end
        end
        dsep_pkg::ST_TRAIL: begin
          // Emit current node; advance along predecessor chain.
          result_valid <= 1'b1;
          trail_node <= cur;
          separated <= 1'b0;
          truncated <= cut;
          last <= 1'b0;
          steps <= steps + CW'(1);
          cur <= predv;
        end
        dsep_pkg::ST_TAIL: begin
          result_valid <= 1'b1;
          trail_node <= xi;
          separated <= 1'b0;
          truncated <= cut;
          last <= 1'b1;
        end
        dsep_pkg::ST_SEP: begin
          result_valid <= 1'b1;
          trail_node <= '0;
          separated <= 1'b1;
          truncated <= 1'b0;
          last <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/dsep_active_trail_search_unit.sv -----
// Top level of the d-separation active-trail search block.
//
// Usage: drive action/node_a/node_b with start; the item is taken as a
// transaction at a rising edge where start is high and busy is low. Edge
// loads, observed marks and graph clears finish at that edge and leave busy
// low, so they can follow every cycle. A query enters the two-entry queue to
// the search engine and holds busy high until its last result is out.
// Query steps: the engine pops the queue, runs an ancestor closure of up to
// NODES sweeps, takes the lowest pending pair and expands each unvisited one
// until the target is reached (or, with none left, gives a separated result),
// dry-walks the predecessor chain for the truncation flag, then gives one
// result per cycle, xj first and xi last. A query naming a node out of use is
// popped straight into the separated state, which registers its single
// separated result. Results sit on trail_node/separated/truncated/last for
// exactly one cycle under result_valid; the receiver cannot stall, so
// nothing back-pressures the engine. Write the node count through
// cfg_we/cfg_wdata only while idle. Reset (rst, synchronous) clears the
// graph, marks, queue and engine and sets the node count to 32.
`default_nettype none
module dsep_active_trail_search_unit #(
  parameter int NODES = dsep_pkg::NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  action,
  input  wire logic [dsep_pkg::NODE_W-1:0] node_a,
  input  wire logic [dsep_pkg::NODE_W-1:0] node_b,
  input  wire logic                        cfg_we,
  input  wire logic [dsep_pkg::NODE_W-1:0] cfg_wdata,
  output logic                             result_valid,
  output logic [dsep_pkg::NODE_W-1:0]      trail_node,
  output logic                             separated,
  output logic                             truncated,
  output logic                             last
);
  logic             q_pop, q_empty, q_full, eng_busy;
  dsep_pkg::query_t q_head;
  logic [NODES:0]   z_head, act;
  logic [NODES:0]   edges [NODES+1];

  // Hold off new items while a query is pending so edges stay stable.
  assign busy = q_full || !q_empty || eng_busy;

  dsep_front #(.NODES(NODES)) u_front (
    .clk, .rst, .take(start && !busy), .action, .node_a, .node_b,
    .cfg_we, .cfg_wdata, .q_pop, .q_empty, .q_full, .q_head, .z_head,
    .act, .edges
  );

  dsep_engine #(.NODES(NODES)) u_engine (
    .clk, .rst, .q_empty, .q_head, .z_head, .act, .edges, .q_pop,
    .eng_busy, .result_valid, .trail_node, .separated, .truncated, .last
  );
endmodule
`default_nettype wire

// ----- test/dsep_active_trail_search_unit_tb.sv -----
// Self-checking testbench for the d-separation active-trail search block.
`timescale 1ns / 1ps
module dsep_active_trail_search_unit_tb;
  localparam int N = dsep_pkg::NODES_DEF;
  localparam int WATCHDOG = 200000;

  // Expected result of one output transaction.
  typedef struct packed {
    logic [dsep_pkg::NODE_W-1:0] node;
    logic                        sep;
    logic                        cut;
    logic                        fin;
  } trail_item_t;

  // One row of the directed stimulus table; has_exp marks rows whose single
  // result is typed in by hand instead of predicted.
  typedef struct packed {
    dsep_pkg::action_t           act;
    logic [dsep_pkg::NODE_W-1:0] a;
    logic [dsep_pkg::NODE_W-1:0] b;
    logic                        has_exp;
    trail_item_t                 exp_item;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] action = 0;
  logic [dsep_pkg::NODE_W-1:0] node_a = 0, node_b = 0;
  logic cfg_we = 0;
  logic [dsep_pkg::NODE_W-1:0] cfg_wdata = 0;
  wire busy, result_valid, separated, truncated, last;
  wire [dsep_pkg::NODE_W-1:0] trail_node;

  dsep_active_trail_search_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .node_a(node_a), .node_b(node_b),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .trail_node(trail_node),
    .separated(separated), .truncated(truncated), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: its own copy of the graph, marks and node count.
  logic [N:0] graph [0:N];
  logic [N:0] marks;
  logic [5:0] count_reg;
  trail_item_t trail_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 25;

  // Append one expected result transaction.
  function automatic void add_expect(int node, logic sep, logic cut, logic fin);
    trail_item_t it;
    it.node = dsep_pkg::NODE_W'(node);
    it.sep = sep;
    it.cut = cut;
    it.fin = fin;
    trail_q.insert(trail_q.size(), it);
  endfunction

  function automatic logic [N:0] in_use_mask();
    logic [N:0] m;
    int n;
    n = (count_reg > N) ? N : count_reg;
    m = '0;
    for (int v = 1; v <= n; v++) m[v] = 1'b1;
    return m;
  endfunction

  function automatic logic [N:0] parents(int y, logic [N:0] m);
    logic [N:0] r;
    r = '0;
    for (int p = 1; p <= N; p++) r[p] = graph[p][y];
    return r & m;
  endfunction

  // Bayes-ball search; appends the expected trail, or a separated result, to trail_q.
  task automatic search_trail(int xi, int xj, logic [N:0] m);
    logic [N:0] z, anc, prev, s;
    logic [2*N+1:0] pend, seen;
    logic [dsep_pkg::NODE_W-1:0] pred [0:N];
    int idx, y, d, cur, steps;
    logic cut;
    int path[$];
    z = marks & m;
    anc = z;
    prev = '0;
    while (prev != anc) begin
      prev = anc;
      for (int v = 1; v <= N; v++) if (prev[v]) anc |= parents(v, m);
    end
    pend = '0;
    seen = '0;
    for (int v = 0; v <= N; v++) pred[v] = '0;
    pend[2*xi+1] = 1'b1;
    pred[xi] = dsep_pkg::NODE_W'(xi);
    while (pend != '0) begin
      idx = 0;
      while (!pend[idx]) idx++;
      pend[idx] = 1'b0;
      if (seen[idx]) continue;
      y = idx >> 1;
      d = idx & 1;
      if (!z[y] && y == xj) begin
        cur = y;
        steps = 0;
        do begin
          path.insert(path.size(), cur);
          steps++;
          cur = pred[cur];
        end while (cur != pred[cur] && steps < N);
        cut = (cur != pred[cur]);
        path.insert(path.size(), xi);
        foreach (path[k])
          add_expect(path[k], 1'b0, cut, k == path.size() - 1);
        return;
      end
      seen[idx] = 1'b1;
      for (int pass = 0; pass < 2; pass++) begin
        // pass 0: children (dir 0); pass 1: parents (dir 1)
        s = '0;
        if (pass == 0 && !z[y]) s = graph[y] & m;
        if (pass == 1 && ((d && !z[y]) || (!d && anc[y]))) s = parents(y, m);
        for (int v = 1; v <= N; v++) if (s[v]) begin
          pend[2*v+(pass == 0 ? 0 : 1)] = 1'b1;
          if (!seen[2*v+(pass == 0 ? 0 : 1)]) pred[v] = dsep_pkg::NODE_W'(y);
        end
      end
    end
    add_expect(0, 1'b1, 1'b0, 1'b1);
  endtask

  // Advance the predictor by one accepted transaction.
  task automatic predict(dsep_pkg::action_t act, int a, int b);
    logic [N:0] m;
    int n;
    bit va, vb;
    m = in_use_mask();
    n = (count_reg > N) ? N : count_reg;
    va = a >= 1 && a <= n;
    vb = b >= 1 && b <= n;
    case (act)
      dsep_pkg::ACT_EDGE: begin
        if (va && vb) graph[a][b] = 1'b1;
      end
      dsep_pkg::ACT_MARK: begin
        if (va) marks[a] = 1'b1;
      end
      dsep_pkg::ACT_QUERY: begin
        if (va && vb) search_trail(a, b, m);
        else add_expect(0, 1'b1, 1'b0, 1'b1);
        marks = '0;
      end
      default: begin
        for (int p = 0; p <= N; p++) graph[p] = '0;
      end
    endcase
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    trail_item_t got, want;
    if (!rst && result_valid) begin
      got = '{trail_node, separated, truncated, last};
      if (trail_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, got);
        errors++;
      end else begin
        want = trail_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves.
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("dsep_active_trail_search_unit_tb failed");
      $finish;
    end
  end

  // Drive one transaction and hold start until accepted; the next call
  // either idles or sends again at once.
  task automatic send(dsep_pkg::action_t act, int a, int b);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    node_a <= dsep_pkg::NODE_W'(a);
    node_b <= dsep_pkg::NODE_W'(b);
    do @(posedge clk); while (busy);
    predict(act, a, b);
    @(negedge clk);
  endtask

  // Drop start, wait for every expected result, then let the engine settle.
  task automatic drain();
    start <= 1'b0;
    while (trail_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= dsep_pkg::NODE_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    count_reg = 6'(v);
  endtask

  // Random item: mostly edges and marks in range, queries now and then,
  // rare clears and out-of-range node numbers.
  task automatic random_item(int hi);
    int r, a, b;
    dsep_pkg::action_t act;
    r = $urandom_range(99);
    act = r < 45 ? dsep_pkg::ACT_EDGE : r < 70 ? dsep_pkg::ACT_MARK :
          r < 97 ? dsep_pkg::ACT_QUERY : dsep_pkg::ACT_CLEAR;
    a = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(hi, 1);
    b = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(hi, 1);
    send(act, a, b);
  endtask

  stim_row_t dir_tbl [] = '{
    '{dsep_pkg::ACT_QUERY, 6'd1, 6'd2, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}},  // empty graph
    '{dsep_pkg::ACT_QUERY, 6'd0, 6'd5, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}},  // node 0
    '{dsep_pkg::ACT_QUERY, 6'd63, 6'd1, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}}, // above range
    '{dsep_pkg::ACT_EDGE, 6'd1, 6'd2, 1'b0, '0},
    '{dsep_pkg::ACT_EDGE, 6'd3, 6'd2, 1'b0, '0},
    '{dsep_pkg::ACT_EDGE, 6'd2, 6'd32, 1'b0, '0},
    '{dsep_pkg::ACT_EDGE, 6'd0, 6'd7, 1'b0, '0},                         // ignored
    '{dsep_pkg::ACT_QUERY, 6'd1, 6'd32, 1'b0, '0},                       // chain
    '{dsep_pkg::ACT_QUERY, 6'd1, 6'd3, 1'b0, '0},                        // blocked collider
    '{dsep_pkg::ACT_MARK, 6'd32, 6'd0, 1'b0, '0},                        // descendant observed
    '{dsep_pkg::ACT_QUERY, 6'd1, 6'd3, 1'b0, '0},
    '{dsep_pkg::ACT_MARK, 6'd2, 6'd0, 1'b0, '0},
    '{dsep_pkg::ACT_QUERY, 6'd1, 6'd32, 1'b0, '0},                       // blocked chain
    '{dsep_pkg::ACT_EDGE, 6'd5, 6'd5, 1'b0, '0},                         // self edge
    '{dsep_pkg::ACT_EDGE, 6'd5, 6'd6, 1'b0, '0},
    '{dsep_pkg::ACT_EDGE, 6'd6, 6'd5, 1'b0, '0},                         // cycle
    '{dsep_pkg::ACT_QUERY, 6'd5, 6'd6, 1'b0, '0},
    '{dsep_pkg::ACT_QUERY, 6'd6, 6'd6, 1'b0, '0},
    '{dsep_pkg::ACT_QUERY, 6'd32, 6'd1, 1'b0, '0},
    '{dsep_pkg::ACT_CLEAR, 6'd0, 6'd0, 1'b0, '0},
    '{dsep_pkg::ACT_MARK, 6'd0, 6'd0, 1'b0, '0},                         // ignored mark
    '{dsep_pkg::ACT_QUERY, 6'd1, 6'd2, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}}  // cleared graph
  };

  initial begin
    int hi;
    for (int p = 0; p <= N; p++) graph[p] = '0;
    marks = '0;
    count_reg = 32;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows; hand-typed rows bypass the predictor's trail.
    foreach (dir_tbl[i]) begin
      send(dir_tbl[i].act, dir_tbl[i].a, dir_tbl[i].b);
      if (dir_tbl[i].has_exp) begin
        void'(trail_q.pop_back());
        trail_q.insert(trail_q.size(), dir_tbl[i].exp_item);
      end
    end

    // Random phases over several node counts, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: hi = 32;
        1: hi = 1;
        2: hi = 6;
        3: hi = 0;
        4: hi = 63;
        default: hi = 8;
      endcase
      set_count(hi);
      send_idle_pct = ph < 2 ? 25 : ph < 4 ? 84 : 0;
      for (int k = 0; k < 35; k++) random_item(hi < 2 ? 2 : (hi > 32 ? 32 : hi));
      drain(); // sender holds off until every expected result has come
    end

    drain();
    if (errors == 0 && trail_q.size() == 0) begin
      $display("dsep_active_trail_search_unit_tb passed");
    end else begin
      $display("dsep_active_trail_search_unit_tb failed");
    end
    $finish;
  end
endmodule
